FILE: rtl/core/brf_pkg.sv
// Shared types, constants and helpers for the byte ring FIFO with bulk read.
// No dependencies; every other file in rtl/core imports this package.
package brf_pkg;

  localparam int DEPTH    = 1024;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int MAX_BULK = 64;
  localparam int CNT_W    = 7;
  localparam int LVL_W    = 10;
  localparam int MODE_W   = 3;
  localparam int STAT_W   = 2;

  typedef logic [PTR_W-1:0] ptr_t;

  // Request operation codes
  localparam logic [MODE_W-1:0] MODE_STORE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BULK  = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_SHORT   = 2'd3;

  // Occupancy figures derived from a pointer pair
  typedef struct packed {
    ptr_t fill;
    ptr_t space;
    logic full;
  } brf_stat_t;

  // Step a pointer round the ring
  function automatic ptr_t advance(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/brf_mem.sv
// Byte storage of the ring: one write port and one registered read port.
// Depends on brf_pkg for the depth and pointer type.
module brf_mem
  import brf_pkg::*;
(
  input  logic       clk,
  input  logic       we,
  input  ptr_t       waddr,
  input  logic [7:0] wdata,
  input  ptr_t       raddr,
  output logic [7:0] rdata
);

  logic [7:0] mem [DEPTH];

  // Write the stored byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the byte at the read address
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/brf_stat.sv
// Occupancy unit: fill level, free space and full flag from a pointer pair.
// Depends on brf_pkg for the pointer type and the status struct.
module brf_stat
  import brf_pkg::*;
(
  input  ptr_t      wp,
  input  ptr_t      rp,
  output brf_stat_t st
);

  logic [PTR_W:0] diff;

  // Distance from read to write pointer round the ring
  always_comb begin
    if (wp >= rp) begin
      diff = {1'b0, wp} - {1'b0, rp};
    end else begin
      diff = {1'b0, wp} + (PTR_W + 1)'(DEPTH) - {1'b0, rp};
    end
  end

  assign st.fill  = diff[PTR_W-1:0];
  assign st.space = ptr_t'(DEPTH - 1) - diff[PTR_W-1:0];
  assign st.full  = (advance(wp) == rp);

endmodule

FILE: rtl/core/byte_ring_fifo_bulk_read_core.sv
// Byte ring FIFO that keeps one slot empty (capacity DEPTH-1) with store, read, peek,
// clear and bulk read requests. One request is handled at a time. Store, clear, unused
// modes, a read or peek of an empty ring and a bulk read answered with a single ok or
// not-enough-bytes result give their result in the cycle after acceptance; a read or
// peek of a stored byte first waits for the registered storage read; a bulk read that
// pops count bytes gives one storage read and one result per byte, paced by the single
// read port. A stalled result holds until it is taken. in_stall is high from acceptance
// until the final result of the request has been taken. Every result reports fill
// level, free space and full flag as they stand after that result's operation.
// Depends on brf_pkg, brf_mem and brf_stat.
module byte_ring_fifo_bulk_read_core
  import brf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] mode,
  input  logic [7:0]        data_in,
  input  logic [CNT_W-1:0]  count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        data_out,
  output logic              byte_valid,
  output logic [STAT_W-1:0] status,
  output logic              last,
  output logic [LVL_W-1:0]  fill_level,
  output logic [LVL_W-1:0]  free_space,
  output logic              full_flag
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]        state, state_next;
  ptr_t              wp, wp_next, rp, rp_next;
  logic [CNT_W-1:0]  remain, remain_next;
  logic              op_pop, op_pop_next, op_bulk, op_bulk_next;
  logic              mem_we;
  logic [7:0]        rd_data;
  logic [7:0]        data_next;
  logic              bvalid_next, last_next;
  logic [STAT_W-1:0] status_next;
  logic              load_out;
  logic              accept, taken;
  brf_stat_t         st_cur, st_nxt;

  assign accept    = in_valid && !in_stall;
  assign taken     = out_valid && !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  brf_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp),
    .wdata (data_in),
    .raddr (rp),
    .rdata (rd_data)
  );

  brf_stat u_stat_cur (
    .wp (wp),
    .rp (rp),
    .st (st_cur)
  );

  brf_stat u_stat_nxt (
    .wp (wp_next),
    .rp (rp_next),
    .st (st_nxt)
  );

  // Sequence one request: decode, wait on the storage read, present each result
  always_comb begin
    state_next   = state;
    wp_next      = wp;
    rp_next      = rp;
    remain_next  = remain;
    op_pop_next  = op_pop;
    op_bulk_next = op_bulk;
    mem_we       = 1'b0;
    load_out     = 1'b0;
    data_next    = '0;
    bvalid_next  = 1'b0;
    status_next  = ST_OK;
    last_next    = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          load_out   = 1'b1;
          state_next = S_OUT;
          unique case (mode)
            MODE_STORE: begin
              if (st_cur.full) begin
                status_next = ST_DROPPED;
              end else begin
                mem_we  = 1'b1;
                wp_next = advance(wp);
              end
            end
            MODE_READ, MODE_PEEK: begin
              if (rp == wp) begin
                status_next = ST_EMPTY;
              end else begin
                load_out     = 1'b0;
                state_next   = S_RD;
                op_pop_next  = (mode == MODE_READ);
                op_bulk_next = 1'b0;
                remain_next  = CNT_W'(1);
              end
            end
            MODE_CLEAR: begin
              wp_next = '0;
              rp_next = '0;
            end
            MODE_BULK: begin
              if (count == '0) begin
                status_next = ST_OK;
              end else if (count > CNT_W'(MAX_BULK) ||
                           (PTR_W + CNT_W)'(st_cur.fill) < (PTR_W + CNT_W)'(count)) begin
                status_next = ST_SHORT;
              end else begin
                load_out     = 1'b0;
                state_next   = S_RD;
                op_pop_next  = 1'b1;
                op_bulk_next = 1'b1;
                remain_next  = count;
              end
            end
            default: begin
              status_next = ST_OK;
            end
          endcase
        end
      end
      S_RD: begin
        load_out    = 1'b1;
        state_next  = S_OUT;
        data_next   = rd_data;
        bvalid_next = 1'b1;
        last_next   = op_bulk ? (remain == CNT_W'(1)) : 1'b1;
        if (op_pop) begin
          rp_next = advance(rp);
        end
      end
      S_OUT: begin
        if (taken) begin
          if (op_bulk && remain != CNT_W'(1)) begin
            remain_next = remain - CNT_W'(1);
            state_next  = S_RD;
          end else begin
            op_bulk_next = 1'b0;
            state_next   = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance control state and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wp      <= '0;
      rp      <= '0;
      remain  <= '0;
      op_pop  <= 1'b0;
      op_bulk <= 1'b0;
    end else begin
      state   <= state_next;
      wp      <= wp_next;
      rp      <= rp_next;
      remain  <= remain_next;
      op_pop  <= op_pop_next;
      op_bulk <= op_bulk_next;
    end
  end

  // Hold the result register until the next result is formed
  always_ff @(posedge clk) begin
    if (load_out) begin
      data_out   <= data_next;
      byte_valid <= bvalid_next;
      status     <= status_next;
      last       <= last_next;
      fill_level <= LVL_W'(st_nxt.fill);
      free_space <= LVL_W'(st_nxt.space);
      full_flag  <= st_nxt.full;
    end
  end

  // A result carrying a byte always reports success
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!byte_valid || status == ST_OK))
    else $error("byte result with non-ok status");

  // A taken result that is not the last keeps the block busy
  a_bulk_busy: assert property (@(posedge clk) disable iff (rst)
    (taken && !last) |=> in_stall)
    else $error("request ended before its final result");

  // A full ring reports no free space
  a_full_space: assert property (@(posedge clk) disable iff (rst)
    (out_valid && full_flag) |-> (free_space == '0))
    else $error("full flag with free space left");

  // No request is taken while a result is pending
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted with result pending");

endmodule
